FILE: sv/slie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slie_pkg
// Shared types and constants for the serial line input editor.
// ----------------------------------------------------------------------------
package slie_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_CHAR    = 2'd1,
        KIND_END     = 2'd2,
        KIND_REFUSED = 2'd3
    } kind_t;

    // command classes handed from front to back
    typedef enum logic [2:0] {
        OP_REFUSE,
        OP_NEWLINE,
        OP_ERASE,
        OP_PRINT,
        OP_BELL
    } op_t;

    // one queued command: class and the 7-bit character for printable bytes
    typedef struct packed {
        op_t        op;
        logic [6:0] ch;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERASE_SP,
        ST_ERASE_BS,
        ST_NL_LF,
        ST_LINE_RD,
        ST_LINE_CHAR,
        ST_LINE_END
    } back_state_t;

    // terminal bytes
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_BELL  = 8'h07;

    // configuration register
    localparam int         CAP_W     = 6;
    localparam logic [5:0] CAP_RESET = 6'd32;
    localparam logic       CAP_WORD  = 1'b0;

endpackage

FILE: sv/slie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slie_front
// Accepts received bytes, sorts them into command classes and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module slie_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    input  logic [slie_pkg::CAP_W-1:0]     cap,
    output logic                           cmd_valid,
    output slie_pkg::cmd_t                 cmd,
    input  logic                           cmd_take
);
    import slie_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    cmd_t       cls;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    // byte classification
    always_comb
    begin
        cls.ch = rx_byte[6:0];
        if (cap < CAP_W'(2))
        begin
            cls.op = OP_REFUSE;
        end
        else if (rx_byte == BYTE_CR || rx_byte == BYTE_LF)
        begin
            cls.op = OP_NEWLINE;
        end
        else if (rx_byte == BYTE_BS || rx_byte == BYTE_DEL)
        begin
            cls.op = OP_ERASE;
        end
        else if (rx_byte >= BYTE_SPACE && rx_byte <= BYTE_TILDE)
        begin
            cls.op = OP_PRINT;
        end
        else
        begin
            cls.op = OP_BELL;
        end
    end

    // queue pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !cmd_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && cmd_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: sv/slie_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slie_back
// Executes queued commands: keeps the line store and fill count and
// sequences the result beats into a one-deep output register.
// ----------------------------------------------------------------------------
module slie_back #(
    parameter int LINE_BYTES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [slie_pkg::CAP_W-1:0]     cap,
    input  logic                           cmd_valid,
    input  slie_pkg::cmd_t                 cmd,
    output logic                           cmd_take,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     kind,
    output logic [7:0]                     data,
    output logic                           last
);
    import slie_pkg::*;

    localparam int IDX_W = $clog2(LINE_BYTES);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] fill_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_inc;
    logic [6:0]       line_mem [LINE_BYTES];
    logic [6:0]       rd_data_reg;
    logic             store_we;
    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic             slot_free;
    logic             emit;
    kind_t            res_kind;
    logic [7:0]       res_data;
    logic             res_last;
    logic [6:0]       cap_eff;
    logic             fits;
    logic             fill_zero;

    assign slot_free = !out_valid_reg || pop;
    assign idx_inc   = idx_reg + IDX_W'(1);
    assign fill_zero = (fill_reg == '0);

    // effective capacity and room check for a printable byte
    assign cap_eff = ({1'b0, cap} > 7'(LINE_BYTES)) ? 7'(LINE_BYTES) : {1'b0, cap};
    assign fits    = (7'(fill_reg) + 7'd1) < cap_eff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    if (cmd.op == OP_NEWLINE)
                    begin
                        state_next = ST_NL_LF;
                    end
                    else if (cmd.op == OP_ERASE && !fill_zero)
                    begin
                        state_next = ST_ERASE_SP;
                    end
                end
            end
            ST_ERASE_SP:
            begin
                if (slot_free)
                begin
                    state_next = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NL_LF:
            begin
                if (slot_free)
                begin
                    state_next = fill_zero ? ST_LINE_END : ST_LINE_RD;
                end
            end
            ST_LINE_RD:
            begin
                state_next = ST_LINE_CHAR;
            end
            ST_LINE_CHAR:
            begin
                if (slot_free)
                begin
                    state_next = (idx_inc == fill_reg) ? ST_LINE_END : ST_LINE_RD;
                end
            end
            ST_LINE_END:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // beat generation and state updates
    always_comb
    begin
        emit      = 1'b0;
        res_kind  = KIND_ECHO;
        res_data  = 8'd0;
        res_last  = 1'b0;
        cmd_take  = 1'b0;
        fill_next = fill_reg;
        idx_next  = idx_reg;
        store_we  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    emit     = 1'b1;
                    unique case (cmd.op)
                        OP_REFUSE:
                        begin
                            res_kind = KIND_REFUSED;
                            res_last = 1'b1;
                        end
                        OP_NEWLINE:
                        begin
                            res_data = BYTE_CR;
                        end
                        OP_ERASE:
                        begin
                            if (!fill_zero)
                            begin
                                res_data  = BYTE_BS;
                                fill_next = fill_reg - IDX_W'(1);
                            end
                            else
                            begin
                                res_data = BYTE_BELL;
                                res_last = 1'b1;
                            end
                        end
                        OP_PRINT:
                        begin
                            res_last = 1'b1;
                            if (fits)
                            begin
                                res_data  = {1'b0, cmd.ch};
                                store_we  = 1'b1;
                                fill_next = fill_reg + IDX_W'(1);
                            end
                            else
                            begin
                                res_data = BYTE_BELL;
                            end
                        end
                        default:
                        begin
                            res_data = BYTE_BELL;
                            res_last = 1'b1;
                        end
                    endcase
                end
            end
            ST_ERASE_SP:
            begin
                emit     = slot_free;
                res_data = BYTE_SPACE;
            end
            ST_ERASE_BS:
            begin
                emit     = slot_free;
                res_data = BYTE_BS;
                res_last = 1'b1;
            end
            ST_NL_LF:
            begin
                emit     = slot_free;
                res_data = BYTE_LF;
                idx_next = '0;
            end
            ST_LINE_RD:
            begin
                emit = 1'b0;
            end
            ST_LINE_CHAR:
            begin
                emit     = slot_free;
                res_kind = KIND_CHAR;
                res_data = {1'b0, rd_data_reg};
                if (slot_free)
                begin
                    idx_next = idx_inc;
                end
            end
            ST_LINE_END:
            begin
                emit     = slot_free;
                res_kind = KIND_END;
                res_data = 8'(fill_reg);
                res_last = 1'b1;
                if (slot_free)
                begin
                    fill_next = '0;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
            out_last_reg <= res_last;
        end
    end

    // line store, registered read at the readout index
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            line_mem[fill_reg] <= cmd.ch;
        end
        rd_data_reg <= line_mem[idx_reg];
    end

    assign empty = !out_valid_reg;
    assign kind  = out_kind_reg;
    assign data  = out_data_reg;
    assign last  = out_last_reg;

endmodule

FILE: sv/serial_line_input_editor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_input_editor_unit
// Line editor for terminal input with echo, backspace and line readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive rx_byte and push; a beat is taken when
//   push is high and full is low. Result side is a queue: while empty is
//   low, kind/data/last show the oldest result; pop takes it.
//   Each input byte gives one or more result beats, the final one with last.
//   line_capacity sits at APB address 0; write it only while idle (not enforced by the block).
// Sequencing:
//   A byte is written into the front queue; once the back end takes it, its
//   first result beat is loaded into the output register and empty goes low.
//   Single-result bytes sustain one per cycle while pop keeps up. Backspace on a
//   non-empty line gives backspace, space and backspace beats. A line end gives CR
//   and LF, each stored character via the registered line-store read, then the end beat.
// Reset:
//   Fill count cleared, queues empty, line_capacity back to 32.
// Stall:
//   With pop low the output register holds its beat, the back end waits,
//   the two-entry front queue fills and then full rises.
// ----------------------------------------------------------------------------
module serial_line_input_editor_unit #(
    parameter int LINE_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // result queue
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic        last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slie_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_take;
    logic             cfg_wr;

    // configuration register
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == CAP_WORD);
    assign cap_next = cfg_wr ? pwdata[CAP_W-1:0] : cap_reg;
    assign prdata   = (paddr[2] == CAP_WORD) ? {{(32 - CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // classify and queue
    slie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cap       (cap_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // execute and emit result beats
    slie_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

    // back end only takes a command that is waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("command taken from an empty queue");

    // a refused beat carries zero data and closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_REFUSED) |-> (data == 8'd0 && last))
        else $error("malformed refused beat");

    // a line-end beat always closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_END) |-> last)
        else $error("line end without last");

    // a taken input shows up in the command queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> cmd_valid)
        else $error("accepted byte lost before the back end");

endmodule
